@@ hdl/two_byte_pattern_row_matcher_assert.svh @@
// assertion macros shared by the matcher modules
// no dependencies; simulation bodies are dropped when SYNTHESIS is defined
`ifndef TWO_BYTE_PATTERN_ROW_MATCHER_ASSERT_SVH
`define TWO_BYTE_PATTERN_ROW_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
// property holds at every edge outside reset
`define TBPRM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tbprm assertion failed");
// consequent holds in the cycle after the antecedent
`define TBPRM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbprm next-cycle assertion failed");
`else
`define TBPRM_ASSERT(name, clk, rst_n, prop)
`define TBPRM_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/tbprm_pkg.sv @@
// shared types and constants of the two-byte pattern row matcher
// no dependencies
`timescale 1ns / 1ps

package tbprm_pkg;

  // default sizes, overridable at the top level
  localparam int unsigned ROW_BEATS_DEF        = 256;
  localparam int unsigned BYTES_PER_BEAT_DEF   = 64;
  localparam int unsigned PAIRS_PER_PACKET_DEF = 8;

  localparam int unsigned NUM_SLOTS  = 8;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned NUM_WORDS  = 8;
  localparam int unsigned MAX_POS    = 63;
  localparam int unsigned IDX_W      = 6;
  localparam logic [7:0]  FLUSH_USER = 8'hF0;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;
  localparam int unsigned QCNT_W = 3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_FIRST  = 3'd0,
    REG_PATTERN_SECOND = 3'd1,
    REG_START_ROW      = 3'd2,
    REG_START_COLUMN   = 3'd3,
    REG_START_FILL     = 3'd4
  } cfg_reg_e;

  // classified beat handed from front to back
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [7:0]       user;
    logic             eoj;
  } class_t;

endpackage

@@ hdl/tbprm_if.sv @@
// valid/ready channel interfaces for beats in and packets out
// no dependencies
`timescale 1ns / 1ps

interface tbprm_beat_if;
  logic        valid;
  logic        ready;
  logic [63:0] word_0;
  logic [63:0] word_1;
  logic [63:0] word_2;
  logic [63:0] word_3;
  logic [63:0] word_4;
  logic [63:0] word_5;
  logic [63:0] word_6;
  logic [63:0] word_7;
  logic [7:0]  user_tag;
  logic        end_of_job;

  modport source (
    output valid, word_0, word_1, word_2, word_3, word_4, word_5, word_6, word_7,
    output user_tag, end_of_job,
    input  ready
  );
  modport sink (
    input  valid, word_0, word_1, word_2, word_3, word_4, word_5, word_6, word_7,
    input  user_tag, end_of_job,
    output ready
  );
endinterface

interface tbprm_pkt_if;
  logic        valid;
  logic        ready;
  logic [63:0] pair_0;
  logic [63:0] pair_1;
  logic [63:0] pair_2;
  logic [63:0] pair_3;
  logic [63:0] pair_4;
  logic [63:0] pair_5;
  logic [63:0] pair_6;
  logic [63:0] pair_7;
  logic [7:0]  out_user;
  logic        out_last;

  modport source (
    output valid, pair_0, pair_1, pair_2, pair_3, pair_4, pair_5, pair_6, pair_7,
    output out_user, out_last,
    input  ready
  );
  modport sink (
    input  valid, pair_0, pair_1, pair_2, pair_3, pair_4, pair_5, pair_6, pair_7,
    input  out_user, out_last,
    output ready
  );
endinterface

@@ hdl/tbprm_front.sv @@
// front end: accepts beats and finds the first pattern position
// depends on tbprm_pkg and tbprm_beat_if
`timescale 1ns / 1ps

module tbprm_front #(
  parameter int unsigned BYTES_PER_BEAT = tbprm_pkg::BYTES_PER_BEAT_DEF
) (
  tbprm_beat_if.sink          beat_i,
  input  logic [7:0]          pat_first_i,
  input  logic [7:0]          pat_second_i,
  output tbprm_pkg::class_t   cls_o,
  output logic                cls_valid_o,
  input  logic                cls_ready_i
);
  import tbprm_pkg::*;

  localparam int unsigned NPOS = BYTES_PER_BEAT - 1;

  logic [8*NUM_WORDS*8-1:0] data;
  logic [MAX_POS-1:0]       hits;
  logic [MAX_POS-1:0]       first_hit;
  logic [IDX_W-1:0]         idx;

  assign data = {beat_i.word_7, beat_i.word_6, beat_i.word_5, beat_i.word_4,
                 beat_i.word_3, beat_i.word_2, beat_i.word_1, beat_i.word_0};

  // independent byte-pair compares, positions past the beat stay clear
  always_comb begin
    for (int i = 0; i < MAX_POS; i++) begin
      hits[i] = (i < NPOS) && (data[8*i +: 8] == pat_first_i) &&
                (data[8*(i+1) +: 8] == pat_second_i);
    end
  end

  // isolate lowest hit, then encode it
  assign first_hit = hits & (~hits + MAX_POS'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < MAX_POS; i++) begin
      idx = idx | (first_hit[i] ? IDX_W'(i) : '0);
    end
  end

  assign cls_o.found = |hits;
  assign cls_o.idx   = idx;
  assign cls_o.user  = beat_i.user_tag;
  assign cls_o.eoj   = beat_i.end_of_job;

  assign cls_valid_o  = beat_i.valid;
  assign beat_i.ready = cls_ready_i;

endmodule

@@ hdl/tbprm_queue.sv @@
// short fifo of classified beats between front and back
// depends on tbprm_pkg and the assertion macro header
`timescale 1ns / 1ps

module tbprm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tbprm_pkg::class_t push_data_i,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  output tbprm_pkg::class_t head_o,
  output logic              head_valid_o,
  input  logic              pop_i
);
  import tbprm_pkg::*;
  `include "two_byte_pattern_row_matcher_assert.svh"

  class_t            mem_q [QDEPTH];
  logic [QAW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QAW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QAW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `TBPRM_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= QCNT_W'(QDEPTH))
  `TBPRM_ASSERT_NEXT(a_cnt_up, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + QCNT_W'(1))
  `TBPRM_ASSERT_NEXT(a_cnt_dn, clk_i, rst_ni, pop && !push, cnt_q == $past(cnt_q) - QCNT_W'(1))

endmodule

@@ hdl/tbprm_back.sv @@
// back end: row and column state, pair buffer and packet output register
// depends on tbprm_pkg, tbprm_pkt_if and the assertion macro header
`timescale 1ns / 1ps

module tbprm_back #(
  parameter int unsigned ROW_BEATS        = tbprm_pkg::ROW_BEATS_DEF,
  parameter int unsigned BYTES_PER_BEAT   = tbprm_pkg::BYTES_PER_BEAT_DEF,
  parameter int unsigned PAIRS_PER_PACKET = tbprm_pkg::PAIRS_PER_PACKET_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [31:0]                  start_row_i,
  input  logic [31:0]                  start_column_i,
  input  logic [tbprm_pkg::SLOT_W-1:0] start_fill_i,
  input  tbprm_pkg::class_t            head_i,
  input  logic                         head_valid_i,
  output logic                         pop_o,
  tbprm_pkt_if.source                  pkt_o
);
  import tbprm_pkg::*;
  `include "two_byte_pattern_row_matcher_assert.svh"

  localparam int unsigned BCW = $clog2(ROW_BEATS + 1);
  localparam logic [BCW-1:0]    RB   = BCW'(ROW_BEATS);
  localparam logic [SLOT_W:0]   PPP  = (SLOT_W + 1)'(PAIRS_PER_PACKET);
  localparam logic [31:0]       STEP = 32'(BYTES_PER_BEAT);

  // state
  logic [31:0]       row_q, row_d;
  logic [31:0]       col_q, col_d;
  logic [BCW-1:0]    bc_q, bc_d;
  logic              rm_q, rm_d;
  logic [SLOT_W-1:0] fill_q, fill_d;
  logic [63:0]       buf_q [NUM_SLOTS];
  logic [63:0]       buf_d [NUM_SLOTS];
  logic              job_q, job_d;

  // output stage
  logic              ov_q, ov_d;
  logic [63:0]       opair_q [NUM_SLOTS];
  logic [63:0]       opair_d [NUM_SLOTS];
  logic [7:0]        ouser_q, ouser_d;
  logic              olast_q, olast_d;
  logic              pend_q, pend_d;

  logic [31:0]       row_s, col_s, row_w, col_w, col_m;
  logic [BCW-1:0]    bc_s;
  logic              rm_s, rm_w, wrap, hit, full_pkt, produce, out_free;
  logic [SLOT_W-1:0] fill_s;
  logic [SLOT_W:0]   fill_nx;
  logic [63:0]       pair;

  always_comb begin
    // job start loads the resume values
    row_s  = job_q ? row_q : start_row_i;
    col_s  = job_q ? col_q : start_column_i;
    fill_s = job_q ? fill_q : start_fill_i;
    bc_s   = job_q ? bc_q : '0;
    rm_s   = job_q && rm_q;

    wrap  = (bc_s == RB);
    row_w = wrap ? row_s + 32'd1 : row_s;
    col_w = wrap ? '0 : col_s;
    rm_w  = wrap ? 1'b0 : rm_s;

    hit      = head_i.found && !rm_w;
    col_m    = col_w + 32'(head_i.idx);
    pair     = {col_m, row_w};
    fill_nx  = {1'b0, fill_s} + (SLOT_W + 1)'(1);
    full_pkt = hit && (fill_nx == PPP);
    produce  = full_pkt || head_i.eoj;

    out_free = !ov_q || (pkt_o.ready && !pend_q);
    pop_o    = head_valid_i && (!produce || out_free);

    for (int s = 0; s < NUM_SLOTS; s++) begin
      buf_d[s] = (hit && (fill_s == SLOT_W'(s))) ? pair : buf_q[s];
    end

    row_d  = row_q;
    col_d  = col_q;
    bc_d   = bc_q;
    rm_d   = rm_q;
    fill_d = fill_q;
    job_d  = job_q;
    if (pop_o) begin
      row_d  = row_w;
      col_d  = col_w + STEP;
      bc_d   = wrap ? '0 : bc_s + BCW'(1);
      rm_d   = rm_w || hit;
      fill_d = hit ? (full_pkt ? '0 : fill_nx[SLOT_W-1:0]) : fill_s;
      job_d  = !head_i.eoj;
    end

    ov_d    = ov_q;
    opair_d = opair_q;
    ouser_d = ouser_q;
    olast_d = olast_q;
    pend_d  = pend_q;
    if (pop_o && produce) begin
      ov_d    = 1'b1;
      opair_d = buf_d;
      ouser_d = full_pkt ? head_i.user : FLUSH_USER;
      olast_d = !full_pkt;
      pend_d  = full_pkt && head_i.eoj;
    end else if (ov_q && pkt_o.ready) begin
      if (pend_q) begin
        // flush follows the full packet with the same slots
        ouser_d = FLUSH_USER;
        olast_d = 1'b1;
        pend_d  = 1'b0;
      end else begin
        ov_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      bc_q   <= '0;
      rm_q   <= 1'b0;
      fill_q <= '0;
      job_q  <= 1'b0;
      ov_q   <= 1'b0;
      pend_q <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        buf_q[s] <= '0;
      end
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      bc_q   <= bc_d;
      rm_q   <= rm_d;
      fill_q <= fill_d;
      job_q  <= job_d;
      ov_q   <= ov_d;
      pend_q <= pend_d;
      if (pop_o) begin
        buf_q <= buf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    opair_q <= opair_d;
    ouser_q <= ouser_d;
    olast_q <= olast_d;
  end

  assign pkt_o.valid    = ov_q;
  assign pkt_o.pair_0   = opair_q[0];
  assign pkt_o.pair_1   = opair_q[1];
  assign pkt_o.pair_2   = opair_q[2];
  assign pkt_o.pair_3   = opair_q[3];
  assign pkt_o.pair_4   = opair_q[4];
  assign pkt_o.pair_5   = opair_q[5];
  assign pkt_o.pair_6   = opair_q[6];
  assign pkt_o.pair_7   = opair_q[7];
  assign pkt_o.out_user = ouser_q;
  assign pkt_o.out_last = olast_q;

  `TBPRM_ASSERT(a_pend_valid, clk_i, rst_ni, !pend_q || ov_q)
  `TBPRM_ASSERT(a_pend_not_last, clk_i, rst_ni, !pend_q || !olast_q)
  `TBPRM_ASSERT(a_beat_bound, clk_i, rst_ni, bc_q <= RB)

endmodule

@@ hdl/two_byte_pattern_row_matcher.sv @@
// path: a beat is registered in the queue, then its packet in the output register
// throughput: one beat per cycle while the queue has room; a beat that ends a full
//   packet and the job holds the output register for both packets (output port bound)
// reset: rst_ni async low clears control state, the pair buffer and registers
//   to zero; no clearing pass, a beat may be taken right after reset
// top level of the matcher; depends on tbprm_pkg, tbprm_if and the sub-modules
`timescale 1ns / 1ps

module two_byte_pattern_row_matcher #(
  parameter int unsigned ROW_BEATS        = tbprm_pkg::ROW_BEATS_DEF,
  parameter int unsigned BYTES_PER_BEAT   = tbprm_pkg::BYTES_PER_BEAT_DEF,
  parameter int unsigned PAIRS_PER_PACKET = tbprm_pkg::PAIRS_PER_PACKET_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tbprm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tbprm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tbprm_beat_if.sink                       beat_i,
  tbprm_pkt_if.source                      pkt_o
);
  import tbprm_pkg::*;

  // configuration registers
  logic [7:0]        pat_first_q;
  logic [7:0]        pat_second_q;
  logic [31:0]       start_row_q;
  logic [31:0]       start_col_q;
  logic [SLOT_W-1:0] start_fill_q;

  // front to queue, queue to back
  class_t            cls;
  logic              cls_valid, cls_ready;
  class_t            head;
  logic              head_valid, pop;

  // writes land at once; the user must change patterns only while idle, the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_first_q  <= '0;
      pat_second_q <= '0;
      start_row_q  <= '0;
      start_col_q  <= '0;
      start_fill_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PATTERN_FIRST:  pat_first_q  <= cfg_data_i[7:0];
        REG_PATTERN_SECOND: pat_second_q <= cfg_data_i[7:0];
        REG_START_ROW:      start_row_q  <= cfg_data_i[31:0];
        REG_START_COLUMN:   start_col_q  <= cfg_data_i[31:0];
        REG_START_FILL:     start_fill_q <= cfg_data_i[SLOT_W-1:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // front: byte-pair compare across the beat, first hit wins
  tbprm_front #(
    .BYTES_PER_BEAT (BYTES_PER_BEAT)
  ) u_front (
    .beat_i       (beat_i),
    .pat_first_i  (pat_first_q),
    .pat_second_i (pat_second_q),
    .cls_o        (cls),
    .cls_valid_o  (cls_valid),
    .cls_ready_i  (cls_ready)
  );

  // decouples intake from the output stall of the back end
  tbprm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (cls),
    .push_valid_i (cls_valid),
    .push_ready_o (cls_ready),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  // back: row/column bookkeeping, buffer update and packet emission;
  // beats that emit nothing keep draining while a packet waits
  tbprm_back #(
    .ROW_BEATS        (ROW_BEATS),
    .BYTES_PER_BEAT   (BYTES_PER_BEAT),
    .PAIRS_PER_PACKET (PAIRS_PER_PACKET)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_row_i    (start_row_q),
    .start_column_i (start_col_q),
    .start_fill_i   (start_fill_q),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .pop_o          (pop),
    .pkt_o          (pkt_o)
  );

endmodule
